### rtl/mdec_pkg.sv
// Shared types and codes for the MIDI message decoder.
// Used by mdec_param_map and midi_message_decoder; no dependencies.
`timescale 1ns / 1ps

package mdec_pkg;

   // Event codes on the result channel.
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_NOTE_ON  = 3'd1;
   localparam logic [2:0] EV_NOTE_OFF = 3'd2;
   localparam logic [2:0] EV_PROG     = 3'd3;
   localparam logic [2:0] EV_SUS_ON   = 3'd4;
   localparam logic [2:0] EV_SUS_OFF  = 3'd5;
   localparam logic [2:0] EV_PARAM    = 3'd6;

   // Highest parameter id the mapper produces.
   localparam logic [4:0] PARAM_ID_MAX = 5'd17;

   // Result of mapping one control change to a synth parameter.
   typedef struct packed {
      logic        hit;
      logic [4:0]  id;
      logic [12:0] value;
   } param_type;

endpackage

### rtl/mdec_param_map.sv
// Control-change to parameter mapping with value scaling.
// Depends on mdec_pkg for param_type.
`timescale 1ns / 1ps

module mdec_param_map (
   input  logic [7:0]         ctrl_num,
   input  logic [7:0]         ctrl_val,
   output mdec_pkg::param_type param
);
   import mdec_pkg::*;

   // Control numbers handled by the mapper.
   localparam logic [7:0] CC_DUTY1   = 8'h4C;
   localparam logic [7:0] CC_DUTY2   = 8'h4D;
   localparam logic [7:0] CC_ATT1    = 8'h49;
   localparam logic [7:0] CC_ATT2    = 8'h50;
   localparam logic [7:0] CC_DEC1    = 8'h4B;
   localparam logic [7:0] CC_DEC2    = 8'h51;
   localparam logic [7:0] CC_SUS1    = 8'h4F;
   localparam logic [7:0] CC_SUS2    = 8'h52;
   localparam logic [7:0] CC_REL1    = 8'h48;
   localparam logic [7:0] CC_REL2    = 8'h53;
   localparam logic [7:0] CC_CUTOFF  = 8'h4A;
   localparam logic [7:0] CC_RESO    = 8'h47;
   localparam logic [7:0] CC_VOLUME  = 8'h55;
   localparam logic [7:0] CC_WAVE1   = 8'h5D;
   localparam logic [7:0] CC_WAVE2   = 8'h12;
   localparam logic [7:0] CC_FILTER  = 8'h13;
   localparam logic [7:0] CC_COARSE  = 8'h10;
   localparam logic [7:0] CC_FINE    = 8'h11;

   logic [12:0] val_shl5;
   logic [12:0] val_shl4;
   logic [12:0] val_shr3;
   logic [12:0] wave_idx;
   logic [12:0] filt_code;
   logic [12:0] coarse;

   // Scaled forms of the control value.
   assign val_shl5 = {ctrl_val, 5'd0};
   assign val_shl4 = {1'b0, ctrl_val, 4'd0};
   assign val_shr3 = {8'd0, ctrl_val[7:3]};
   assign coarse   = 13'({7'd0, ctrl_val[7:2]} * 13'd100);

   // Wave index is v*5/127 clamped to 4; the quotient steps at fixed thresholds.
   always_comb begin
      if (ctrl_val >= 8'd102) begin
         wave_idx = 13'd4;
      end else if (ctrl_val >= 8'd77) begin
         wave_idx = 13'd3;
      end else if (ctrl_val >= 8'd51) begin
         wave_idx = 13'd2;
      end else if (ctrl_val >= 8'd26) begin
         wave_idx = 13'd1;
      end else begin
         wave_idx = 13'd0;
      end
   end

   // Filter mode is v>>5 clamped to 3.
   assign filt_code = ctrl_val[7] ? 13'd3 : {11'd0, ctrl_val[6:5]};

   // Select id and value by control number.
   always_comb begin
      param.hit   = 1'b1;
      param.id    = 5'd0;
      param.value = 13'd0;
      case (ctrl_num)
         CC_DUTY1:  begin param.id = 5'd0;  param.value = val_shl5;  end
         CC_DUTY2:  begin param.id = 5'd1;  param.value = val_shl5;  end
         CC_ATT1:   begin param.id = 5'd2;  param.value = val_shr3;  end
         CC_ATT2:   begin param.id = 5'd3;  param.value = val_shr3;  end
         CC_DEC1:   begin param.id = 5'd4;  param.value = val_shr3;  end
         CC_DEC2:   begin param.id = 5'd5;  param.value = val_shr3;  end
         CC_SUS1:   begin param.id = 5'd6;  param.value = val_shr3;  end
         CC_SUS2:   begin param.id = 5'd7;  param.value = val_shr3;  end
         CC_REL1:   begin param.id = 5'd8;  param.value = val_shr3;  end
         CC_REL2:   begin param.id = 5'd9;  param.value = val_shr3;  end
         CC_CUTOFF: begin param.id = 5'd10; param.value = val_shl4;  end
         CC_RESO:   begin param.id = 5'd11; param.value = val_shr3;  end
         CC_VOLUME: begin param.id = 5'd12; param.value = val_shr3;  end
         CC_WAVE1:  begin param.id = 5'd13; param.value = wave_idx;  end
         CC_WAVE2:  begin param.id = 5'd14; param.value = wave_idx;  end
         CC_FILTER: begin param.id = 5'd15; param.value = filt_code; end
         CC_COARSE: begin param.id = 5'd16; param.value = coarse;    end
         CC_FINE:   begin param.id = PARAM_ID_MAX; param.value = {5'd0, ctrl_val}; end
         default: begin
            param.hit = 1'b0;
         end
      endcase
   end

endmodule

### rtl/midi_message_decoder.sv
// MIDI byte-stream decoder top level: input register, parser, result register.
// Depends on mdec_pkg and mdec_param_map.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_rx_byte
//   rsp      out        rsp_valid/rsp_ready  rsp_event_kind .. rsp_param_value
//
// One byte enters per cycle while req_ready is high; results leave the result register.
// The parser state is updated as a byte leaves the input register.
// A stalled result holds the result register; the input register still
// takes one byte, so req_ready drops only when both stages are full.
// Reset returns the parser to idle and clears the program number.
`timescale 1ns / 1ps

module midi_message_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_note_key,
   output logic [7:0]  rsp_note_velocity,
   output logic [6:0]  rsp_program_now,
   output logic [4:0]  rsp_param_id,
   output logic [12:0] rsp_param_value
);
   import mdec_pkg::*;

   // Parser phases.
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_ON_K  = 3'd1;
   localparam logic [2:0] PH_ON_V  = 3'd2;
   localparam logic [2:0] PH_OFF_K = 3'd3;
   localparam logic [2:0] PH_OFF_V = 3'd4;
   localparam logic [2:0] PH_CC_C  = 3'd5;
   localparam logic [2:0] PH_CC_V  = 3'd6;
   localparam logic [2:0] PH_PROG  = 3'd7;

   // Status nibbles and special controls.
   localparam logic [3:0] ST_NOTE_ON  = 4'h9;
   localparam logic [3:0] ST_NOTE_OFF = 4'h8;
   localparam logic [3:0] ST_CTRL     = 4'hB;
   localparam logic [3:0] ST_PROG     = 4'hC;
   localparam logic [7:0] CC_SUSTAIN  = 8'd64;
   localparam logic [7:0] CC_WHEEL    = 8'h72;
   localparam logic [7:0] WHEEL_UP    = 8'h41;
   localparam logic [7:0] WHEEL_DOWN  = 8'h3F;
   localparam logic [6:0] PROG_MAX    = 7'd127;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  first_ff, first_in;
   logic [6:0]  program_ff, program_in;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  key_ff, key_in;
   logic [7:0]  vel_ff, vel_in;
   logic [4:0]  pid_ff, pid_in;
   logic [12:0] pval_ff, pval_in;
   logic        out_free;
   logic        step;
   param_type   param;

   // Handshake: the result register frees when empty or taken.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // Input register.
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   mdec_param_map u_param_map (
      .ctrl_num (first_ff),
      .ctrl_val (in_byte_ff),
      .param    (param)
   );

   // Parser: next state and result for the byte in the input register.
   always_comb begin
      phase_in   = phase_ff;
      first_in   = first_ff;
      program_in = program_ff;
      kind_in    = EV_NONE;
      key_in     = 8'd0;
      vel_in     = 8'd0;
      pid_in     = 5'd0;
      pval_in    = 13'd0;
      case (phase_ff)
         PH_IDLE: begin
            case (in_byte_ff[7:4])
               ST_NOTE_ON:  phase_in = PH_ON_K;
               ST_NOTE_OFF: phase_in = PH_OFF_K;
               ST_CTRL:     phase_in = PH_CC_C;
               ST_PROG:     phase_in = PH_PROG;
               default:     phase_in = PH_IDLE;
            endcase
         end
         PH_PROG: begin
            program_in = in_byte_ff[7] ? PROG_MAX : in_byte_ff[6:0];
            kind_in    = EV_PROG;
            phase_in   = PH_IDLE;
         end
         PH_ON_K, PH_OFF_K, PH_CC_C: begin
            first_in = in_byte_ff;
            phase_in = phase_ff + 3'd1;
         end
         PH_ON_V, PH_OFF_V: begin
            kind_in  = (phase_ff == PH_ON_V) ? EV_NOTE_ON : EV_NOTE_OFF;
            key_in   = first_ff;
            vel_in   = in_byte_ff;
            phase_in = PH_IDLE;
         end
         PH_CC_V: begin
            phase_in = PH_IDLE;
            if (first_ff == CC_SUSTAIN) begin
               kind_in = (in_byte_ff > 8'd63) ? EV_SUS_ON : EV_SUS_OFF;
            end else if (first_ff == CC_WHEEL) begin
               if (in_byte_ff == WHEEL_UP) begin
                  if (program_ff != PROG_MAX) begin
                     program_in = program_ff + 7'd1;
                  end
                  kind_in = EV_PROG;
               end else if (in_byte_ff == WHEEL_DOWN) begin
                  if (program_ff != 7'd0) begin
                     program_in = program_ff - 7'd1;
                  end
                  kind_in = EV_PROG;
               end
            end else if (param.hit) begin
               kind_in = EV_PARAM;
               pid_in  = param.id;
               pval_in = param.value;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Parser state advances once per byte leaving the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         first_ff   <= 8'd0;
         program_ff <= 7'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         first_ff   <= first_in;
         program_ff <= program_in;
      end
   end

   // Result register.
   assign out_valid_in = step || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step) begin
         kind_ff <= kind_in;
         key_ff  <= key_in;
         vel_ff  <= vel_in;
         pid_ff  <= pid_in;
         pval_ff <= pval_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_note_key      = key_ff;
   assign rsp_note_velocity = vel_ff;
   assign rsp_param_id      = pid_ff;
   assign rsp_param_value   = pval_ff;

   // Program number travels with the result it belongs to.
   logic [6:0] prog_out_ff;
   always_ff @(posedge clock) begin
      if (step) begin
         prog_out_ff <= program_in;
      end
   end
   assign rsp_program_now = prog_out_ff;

`ifndef SYNTHESIS
   // A note-on key byte is always followed by its velocity phase.
   a_on_key_next: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_ON_K) |=> phase_ff == PH_ON_V)
      else $error("note-on key not followed by velocity phase");

   // Key and velocity are zero outside note events.
   a_note_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && kind_ff != EV_NOTE_ON && kind_ff != EV_NOTE_OFF)
         |-> (key_ff == 8'd0 && vel_ff == 8'd0))
      else $error("note fields set on a non-note event");

   // The program register moves only when a byte is parsed.
   a_prog_stable: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(program_ff))
      else $error("program changed without a parsed byte");

   // Parameter ids stay in the defined range.
   a_pid_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> pid_ff <= PARAM_ID_MAX)
      else $error("parameter id out of range");

   // A stalled input byte leaves the parser state alone.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> $stable(phase_ff))
      else $error("parser phase moved while stalled");
`endif

endmodule

### tb/sv/midi_message_decoder_test.sv
// Self-checking testbench for midi_message_decoder: directed and random byte streams.
// Depends on mdec_pkg for event codes; holds its own decoder model to predict results.
`timescale 1ns / 1ps

module midi_message_decoder_test;
   import mdec_pkg::*;

   // Parser phases of the model.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ON_KEY,
      ST_ON_VEL,
      ST_OFF_KEY,
      ST_OFF_VEL,
      ST_CTL_NUM,
      ST_CTL_VAL,
      ST_PROG_NUM
   } phase_type;

   // Synth parameter ids, in the order the result channel numbers them.
   typedef enum logic [4:0] {
      P_DUTY1, P_DUTY2, P_ATT1, P_ATT2, P_DEC1, P_DEC2, P_SUS1, P_SUS2,
      P_REL1, P_REL2, P_CUTOFF, P_RESO, P_VOLUME, P_WAVE1, P_WAVE2,
      P_FILTER, P_DIFF_COARSE, P_DIFF_FINE
   } param_id_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  key;
      logic [7:0]  velocity;
      logic [6:0]  prog_now;
      logic [4:0]  pid;
      logic [12:0] pvalue;
   } midi_event_type;

   localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
   localparam logic [3:0] NIB_CONTROL  = 4'hB;
   localparam logic [3:0] NIB_PROGRAM  = 4'hC;

   localparam logic [7:0] CTL_SUSTAIN = 8'h40;
   localparam logic [7:0] CTL_WHEEL   = 8'h72;
   localparam logic [7:0] WHEEL_UP    = 8'h41;
   localparam logic [7:0] WHEEL_DOWN  = 8'h3F;
   localparam logic [6:0] PROGRAM_TOP = 7'd127;

   // Control numbers of the synth parameters.
   localparam logic [7:0] CTL_DUTY1  = 8'h4C;
   localparam logic [7:0] CTL_DUTY2  = 8'h4D;
   localparam logic [7:0] CTL_ATT1   = 8'h49;
   localparam logic [7:0] CTL_ATT2   = 8'h50;
   localparam logic [7:0] CTL_DEC1   = 8'h4B;
   localparam logic [7:0] CTL_DEC2   = 8'h51;
   localparam logic [7:0] CTL_SUS1   = 8'h4F;
   localparam logic [7:0] CTL_SUS2   = 8'h52;
   localparam logic [7:0] CTL_REL1   = 8'h48;
   localparam logic [7:0] CTL_REL2   = 8'h53;
   localparam logic [7:0] CTL_CUTOFF = 8'h4A;
   localparam logic [7:0] CTL_RESO   = 8'h47;
   localparam logic [7:0] CTL_VOLUME = 8'h55;
   localparam logic [7:0] CTL_WAVE1  = 8'h5D;
   localparam logic [7:0] CTL_WAVE2  = 8'h12;
   localparam logic [7:0] CTL_FILTER = 8'h13;
   localparam logic [7:0] CTL_COARSE = 8'h10;
   localparam logic [7:0] CTL_FINE   = 8'h11;

   // Control numbers the decoder knows, used to bias the random stream.
   localparam logic [7:0] KNOWN_CTL [20] = '{
      CTL_DUTY1, CTL_DUTY2, CTL_ATT1, CTL_ATT2, CTL_DEC1, CTL_DEC2, CTL_SUS1,
      CTL_SUS2, CTL_REL1, CTL_REL2, CTL_CUTOFF, CTL_RESO, CTL_VOLUME, CTL_WAVE1,
      CTL_WAVE2, CTL_FILTER, CTL_COARSE, CTL_FINE, CTL_SUSTAIN, CTL_WHEEL
   };

   localparam int HOLD_CYCLES = 80;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_event_kind;
   logic [7:0]  rsp_note_key;
   logic [7:0]  rsp_note_velocity;
   logic [6:0]  rsp_program_now;
   logic [4:0]  rsp_param_id;
   logic [12:0] rsp_param_value;

   // Model state.
   phase_type  mdl_phase;
   logic [7:0] mdl_held;
   logic [6:0] mdl_program;

   midi_event_type pending_events [$];
   int errors;
   int bytes_sent;
   bit sender_idles;
   bit receiver_stalls;
   bit hold_request;

   midi_message_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_note_key      (rsp_note_key),
      .rsp_note_velocity (rsp_note_velocity),
      .rsp_program_now   (rsp_program_now),
      .rsp_param_id      (rsp_param_id),
      .rsp_param_value   (rsp_param_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Maps a control number and value to a parameter id and its scaled value.
   function automatic bit map_control(input logic [7:0] ctl, input logic [7:0] v,
                                      output logic [4:0] id, output logic [12:0] value);
      int t;
      map_control = 1'b1;
      id = '0;
      value = '0;
      case (ctl)
         CTL_DUTY1:  begin id = P_DUTY1;  value = {v, 5'b0}; end
         CTL_DUTY2:  begin id = P_DUTY2;  value = {v, 5'b0}; end
         CTL_ATT1:   begin id = P_ATT1;   value = 13'(v >> 3); end
         CTL_ATT2:   begin id = P_ATT2;   value = 13'(v >> 3); end
         CTL_DEC1:   begin id = P_DEC1;   value = 13'(v >> 3); end
         CTL_DEC2:   begin id = P_DEC2;   value = 13'(v >> 3); end
         CTL_SUS1:   begin id = P_SUS1;   value = 13'(v >> 3); end
         CTL_SUS2:   begin id = P_SUS2;   value = 13'(v >> 3); end
         CTL_REL1:   begin id = P_REL1;   value = 13'(v >> 3); end
         CTL_REL2:   begin id = P_REL2;   value = 13'(v >> 3); end
         CTL_CUTOFF: begin id = P_CUTOFF; value = {1'b0, v, 4'b0}; end
         CTL_RESO:   begin id = P_RESO;   value = 13'(v >> 3); end
         CTL_VOLUME: begin id = P_VOLUME; value = 13'(v >> 3); end
         CTL_WAVE1, CTL_WAVE2: begin
            // The wave index overruns at the top value and is held at 4.
            t = (int'(v) * 5) / 127;
            if (t > 4) t = 4;
            id = (ctl == CTL_WAVE1) ? P_WAVE1 : P_WAVE2;
            value = 13'(t);
         end
         CTL_FILTER: begin
            t = int'(v) >> 5;
            if (t > 3) t = 3;
            id = P_FILTER;
            value = 13'(t);
         end
         CTL_COARSE: begin id = P_DIFF_COARSE; value = 13'(int'(v >> 2) * 100); end
         CTL_FINE:   begin id = P_DIFF_FINE;   value = 13'(v); end
         default: map_control = 1'b0;
      endcase
   endfunction

   // Advances the model by one byte and returns the event it yields.
   function automatic midi_event_type decode_byte(input logic [7:0] b);
      midi_event_type e;
      logic [4:0]     id;
      logic [12:0]    value;
      e = '0;
      case (mdl_phase)
         ST_IDLE: begin
            case (b[7:4])
               NIB_NOTE_ON:  mdl_phase = ST_ON_KEY;
               NIB_NOTE_OFF: mdl_phase = ST_OFF_KEY;
               NIB_CONTROL:  mdl_phase = ST_CTL_NUM;
               NIB_PROGRAM:  mdl_phase = ST_PROG_NUM;
               default: ;
            endcase
         end
         ST_PROG_NUM: begin
            mdl_program = b[7] ? PROGRAM_TOP : b[6:0];
            e.kind = EV_PROG;
            mdl_phase = ST_IDLE;
         end
         ST_ON_KEY: begin
            mdl_held = b;
            mdl_phase = ST_ON_VEL;
         end
         ST_ON_VEL: begin
            e.kind = EV_NOTE_ON;
            e.key = mdl_held;
            e.velocity = b;
            mdl_phase = ST_IDLE;
         end
         ST_OFF_KEY: begin
            mdl_held = b;
            mdl_phase = ST_OFF_VEL;
         end
         ST_OFF_VEL: begin
            e.kind = EV_NOTE_OFF;
            e.key = mdl_held;
            e.velocity = b;
            mdl_phase = ST_IDLE;
         end
         ST_CTL_NUM: begin
            mdl_held = b;
            mdl_phase = ST_CTL_VAL;
         end
         default: begin
            mdl_phase = ST_IDLE;
            if (mdl_held == CTL_SUSTAIN) begin
               e.kind = (b > 8'd63) ? EV_SUS_ON : EV_SUS_OFF;
            end else if (mdl_held == CTL_WHEEL) begin
               // The program wheel steps by one and saturates at both ends.
               if (b == WHEEL_UP) begin
                  if (mdl_program < PROGRAM_TOP) mdl_program = mdl_program + 7'd1;
                  e.kind = EV_PROG;
               end else if (b == WHEEL_DOWN) begin
                  if (mdl_program > 7'd0) mdl_program = mdl_program - 7'd1;
                  e.kind = EV_PROG;
               end
            end else if (map_control(mdl_held, b, id, value)) begin
               e.kind = EV_PARAM;
               e.pid = id;
               e.pvalue = value;
            end
         end
      endcase
      e.prog_now = mdl_program;
      return e;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Offers one byte, waits for its transfer and records the predicted event.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_events.push_back(decode_byte(b));
      bytes_sent++;
   endtask

   // Data byte: mostly in the MIDI range, with the extremes and bit 7 set now and then.
   function automatic logic [7:0] random_data();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h7F;
         3, 4:    return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(0, 127));
      endcase
   endfunction

   // Sends one random message; most are well formed, the rest noise or truncated.
   task automatic send_message();
      int         pick;
      logic [7:0] ctl;
      logic [7:0] value;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 28) begin
         send_byte({($urandom_range(0, 1) != 0) ? NIB_NOTE_ON : NIB_NOTE_OFF,
                    4'($urandom_range(0, 15))});
         send_byte(random_data());
         send_byte(random_data());
      end else if (pick < 75) begin
         if ($urandom_range(0, 9) < 8) ctl = KNOWN_CTL[5'($urandom_range(0, 19))];
         else ctl = 8'($urandom_range(0, 255));
         value = random_data();
         if (ctl == CTL_WHEEL && $urandom_range(0, 9) < 7)
            value = ($urandom_range(0, 1) != 0) ? WHEEL_UP : WHEEL_DOWN;
         send_byte({NIB_CONTROL, 4'($urandom_range(0, 15))});
         send_byte(ctl);
         send_byte(value);
      end else if (pick < 90) begin
         send_byte({NIB_PROGRAM, 4'($urandom_range(0, 15))});
         send_byte(random_data());
      end else begin
         // A lone status byte; whatever follows is taken as its data.
         case ($urandom_range(0, 3))
            0:       send_byte({NIB_NOTE_ON, 4'($urandom_range(0, 15))});
            1:       send_byte({NIB_NOTE_OFF, 4'($urandom_range(0, 15))});
            2:       send_byte({NIB_CONTROL, 4'($urandom_range(0, 15))});
            default: send_byte({NIB_PROGRAM, 4'($urandom_range(0, 15))});
         endcase
      end
   endtask

   task automatic send_messages(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) send_message();
   endtask

   // Drops valid and waits until every predicted event has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   // Extremes of the fields and each special case of the parser.
   task automatic test_directed();
      logic [7:0] stream [30] = '{
         8'h00,                // unknown status in idle is dropped
         8'h9F, 8'h00, 8'hFF,  // note on, key and velocity extremes
         8'h80, 8'hFF, 8'h00,  // note off, key byte with bit 7 set
         8'hB5, 8'h72, 8'h3F,  // wheel down while the program is 0
         8'hC2, 8'hFF,         // program number above 127 saturates
         8'hB0, 8'h72, 8'h41,  // wheel up while the program is 127
         8'hB0, 8'h40, 8'h40,  // sustain on
         8'hB0, 8'h40, 8'h3F,  // sustain off
         8'hBF, 8'h5D, 8'h7F,  // wave index clamped
         8'hB0, 8'h13, 8'hFF,  // filter code clamped
         8'hB0, 8'h00, 8'h55   // unknown control number
      };
      foreach (stream[i]) send_byte(stream[i]);
   endtask

   task automatic test_random_traffic();
      send_messages(300);
   endtask

   // The receiver holds off long enough for the input side to stall.
   task automatic test_receiver_holdoff();
      hold_request = 1'b1;
      send_messages(40);
   endtask

   // The sender stops until all events are out, then resumes.
   task automatic test_sender_pause();
      send_messages(30);
      wait_drained();
      send_messages(30);
   endtask

   // Back-to-back transfers with no idling on either side.
   task automatic test_steady_stream();
      sender_idles = 1'b0;
      receiver_stalls = 1'b0;
      send_messages(100);
   endtask

   // Result receiver: random stalls, plus one long hold-off on request.
   initial begin
      int n;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 11);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compares each result transfer with the oldest predicted event.
   always @(posedge clock) begin
      midi_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d",
                     $time, rsp_event_kind);
         end else begin
            want = pending_events.pop_front();
            check_field("event_kind", want.kind, rsp_event_kind);
            check_field("note_key", want.key, rsp_note_key);
            check_field("note_velocity", want.velocity, rsp_note_velocity);
            check_field("program_now", want.prog_now, rsp_program_now);
            check_field("param_id", want.pid, rsp_param_id);
            check_field("param_value", want.pvalue, rsp_param_value);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      errors = 0;
      bytes_sent = 0;
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      hold_request = 1'b0;
      mdl_phase = ST_IDLE;
      mdl_held = '0;
      mdl_program = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic();
      test_receiver_holdoff();
      test_sender_pause();
      test_steady_stream();

      // Let the pipeline empty, then wait for stray results.
      wait_drained();
      repeat (5) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
